// ===== sv/ole_pkg.sv =====
// shared types, codes and defaults for the ordered list engine
package ole_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int COUNT_FW        = 5;

  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_DELETE     = 3'd4;
  localparam logic [2:0] FUNC_SEARCH     = 3'd5;
  localparam logic [2:0] FUNC_SWAP       = 3'd6;
  localparam logic [2:0] FUNC_NOP        = 3'd7;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_REFUSED   = 2'd3;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] second_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_FW-1:0]      entry_count;
  } out_item_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic del;
    logic swap;
  } cell_cmd_t;

  // seen-so-far flags, front to back
  typedef struct packed {
    logic seen1;
    logic seen2;
  } fwd_link_t;

  // later match inside the swap window, back to front
  typedef struct packed {
    logic later1;
    logic later2;
  } bwd_link_t;

endpackage

// ===== sv/ole_cell.sv =====
// one list position: holds an entry, compares it and shifts with its neighbours
module ole_cell #(
  parameter int VW  = ole_pkg::VALUE_WIDTH_DEF,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  ole_pkg::cell_cmd_t cmd_i,
  input  logic [VW-1:0]     v1_i,
  input  logic [VW-1:0]     v2_i,
  input  logic [CW-1:0]     count_i,
  input  logic [VW-1:0]     left_i,
  input  logic [VW-1:0]     right_i,
  input  ole_pkg::fwd_link_t fwd_i,
  input  ole_pkg::bwd_link_t bwd_i,
  output logic [VW-1:0]     val_o,
  output logic              last_o,
  output ole_pkg::fwd_link_t fwd_o,
  output ole_pkg::bwd_link_t bwd_o
);

  logic [VW-1:0] val_r;
  logic [VW-1:0] val_nxt;
  logic          occ;
  logic          m1;
  logic          m2;
  logic          in_window;
  logic          at_tail;
  logic          is_p1;
  logic          is_p2;

  assign occ       = CW'(IDX) < count_i;
  assign at_tail   = CW'(IDX) == count_i;
  assign last_o    = CW'(IDX + 1) == count_i;
  assign m1        = occ && (val_r == v1_i);
  assign m2        = occ && (val_r == v2_i);
  assign in_window = !(fwd_i.seen1 && fwd_i.seen2);

  assign fwd_o.seen1  = fwd_i.seen1 | m1;
  assign fwd_o.seen2  = fwd_i.seen2 | m2;
  assign bwd_o.later1 = bwd_i.later1 | (m1 & in_window);
  assign bwd_o.later2 = bwd_i.later2 | (m2 & in_window);

  // latest occurrence of each value up to the stop position
  assign is_p1 = m1 && in_window && !bwd_i.later1;
  assign is_p2 = m2 && in_window && !bwd_i.later2;

  always_comb begin
    val_nxt = val_r;
    if (cmd_i.push_front) begin
      val_nxt = left_i;
    end else if (cmd_i.pop_front || (cmd_i.del && fwd_o.seen1)) begin
      val_nxt = right_i;
    end else if (cmd_i.push_back && at_tail) begin
      val_nxt = v1_i;
    end else if (cmd_i.swap && is_p1) begin
      val_nxt = v2_i;
    end else if (cmd_i.swap && is_p2) begin
      val_nxt = v1_i;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

// ===== sv/ordered_list_engine.sv =====
// top level of the ordered list engine: decode, cell row and result register
// result: registered, valid from the cycle after the input transfer
// throughput: one item per cycle while results are taken; the whole row of
//   cells compares and shifts in that single cycle
// reset (synchronous, rst_n low) empties the list and drops any pending
//   result; stored entries are not cleared
module ordered_list_engine #(
  parameter int CAPACITY    = ole_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = ole_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ole_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ole_pkg::out_item_t out_data
);

  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int DATA_W   = ole_pkg::DATA_W;
  localparam int COUNT_FW = ole_pkg::COUNT_FW;

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_valid_r;
  ole_pkg::out_item_t     out_data_r;
  ole_pkg::out_item_t     out_data_nxt;
  logic                   in_accept;
  logic [VALUE_WIDTH-1:0] v1;
  logic [VALUE_WIDTH-1:0] v2;
  logic                   full;
  logic                   empty;
  logic                   found1;
  logic                   found_both;
  logic                   swap_legal;
  logic [VALUE_WIDTH-1:0] tail_val;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [1:0]             status;
  ole_pkg::cell_cmd_t     cmd_raw;
  ole_pkg::cell_cmd_t     cmd;

  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic                   cell_last [CAPACITY];
  ole_pkg::fwd_link_t     fwd_chain [CAPACITY+1];
  ole_pkg::bwd_link_t     bwd_chain [CAPACITY+1];

  assign in_accept = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;

  assign v1 = VALUE_WIDTH'(in_data.value);
  assign v2 = VALUE_WIDTH'(in_data.second_value);

  assign full       = count_r == CW'(CAPACITY);
  assign empty      = count_r == '0;
  assign found1     = fwd_chain[CAPACITY].seen1;
  assign found_both = fwd_chain[CAPACITY].seen1 && fwd_chain[CAPACITY].seen2;
  assign swap_legal = (count_r >= CW'(2)) && (v1 != v2);

  assign fwd_chain[0]        = '0;
  assign bwd_chain[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val;
    logic [VALUE_WIDTH-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = v1;
    end else begin : g_body
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    ole_cell #(
      .VW  (VALUE_WIDTH),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .cmd_i   (cmd),
      .v1_i    (v1),
      .v2_i    (v2),
      .count_i (count_r),
      .left_i  (left_val),
      .right_i (right_val),
      .fwd_i   (fwd_chain[i]),
      .bwd_i   (bwd_chain[i+1]),
      .val_o   (cell_val[i]),
      .last_o  (cell_last[i]),
      .fwd_o   (fwd_chain[i+1]),
      .bwd_o   (bwd_chain[i])
    );
  end

  // tail entry: exactly one cell flags itself as last when the list is not empty
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_val = tail_val | (cell_last[i] ? cell_val[i] : '0);
    end
  end

  always_comb begin
    cmd_raw   = '0;
    status    = ole_pkg::STAT_OK;
    rd_val    = '0;
    count_nxt = count_r;
    unique case (in_data.func) inside
      ole_pkg::FUNC_PUSH_FRONT, ole_pkg::FUNC_PUSH_BACK: begin
        if (full) begin
          status = ole_pkg::STAT_FULL;
        end else begin
          count_nxt          = count_r + CW'(1);
          cmd_raw.push_front = in_data.func == ole_pkg::FUNC_PUSH_FRONT;
          cmd_raw.push_back  = in_data.func == ole_pkg::FUNC_PUSH_BACK;
        end
      end
      ole_pkg::FUNC_POP_FRONT, ole_pkg::FUNC_POP_BACK: begin
        if (empty) begin
          status = ole_pkg::STAT_NOT_FOUND;
        end else begin
          count_nxt = count_r - CW'(1);
          if (in_data.func == ole_pkg::FUNC_POP_FRONT) begin
            rd_val            = cell_val[0];
            cmd_raw.pop_front = 1'b1;
          end else begin
            rd_val = tail_val;
          end
        end
      end
      ole_pkg::FUNC_DELETE: begin
        if (!found1) begin
          status = ole_pkg::STAT_NOT_FOUND;
        end else begin
          count_nxt   = count_r - CW'(1);
          cmd_raw.del = 1'b1;
        end
      end
      ole_pkg::FUNC_SEARCH: begin
        if (!found1) begin
          status = ole_pkg::STAT_NOT_FOUND;
        end
      end
      ole_pkg::FUNC_SWAP: begin
        if (!swap_legal) begin
          status = ole_pkg::STAT_REFUSED;
        end else if (!found_both) begin
          status = ole_pkg::STAT_NOT_FOUND;
        end else begin
          cmd_raw.swap = 1'b1;
        end
      end
      ole_pkg::FUNC_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign cmd = in_accept ? cmd_raw : '0;

  always_comb begin
    out_data_nxt.status      = status;
    out_data_nxt.read_value  = DATA_W'(rd_val);
    out_data_nxt.entry_count = COUNT_FW'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/ole_checker.sv =====
// port-level checks for the ordered list engine, bound to the top level
module ole_checker #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ole_pkg::out_item_t out_data
);

  localparam int COUNT_FW = ole_pkg::COUNT_FW;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // full status only when the list really is at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ole_pkg::STAT_FULL)
      |-> out_data.entry_count == COUNT_FW'(CAPACITY))
    else $error("full reported below capacity");

  // a nonzero read value only comes with a successful operation
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.read_value != '0) |-> out_data.status == ole_pkg::STAT_OK)
    else $error("read value on failed operation");

  // no result pending straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with no result pending the input side is open
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while idle");

endmodule

bind ordered_list_engine ole_checker #(
  .CAPACITY (CAPACITY)
) u_ole_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
